// ----- hw/rtl/fsk_pkg.sv -----
package fsk_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_TICK_RATE   = 3'd1;
  localparam logic [2:0] REG_SYMBOL      = 3'd2;
  localparam logic [2:0] REG_MARK        = 3'd3;
  localparam logic [2:0] REG_SPACE       = 3'd4;
  localparam logic [2:0] REG_OFFSET_STEP = 3'd5;

  // Configuration reset values.
  localparam logic        RST_MODE        = 1'b0;
  localparam logic [29:0] RST_TICK_RATE   = 30'd1000000;
  localparam logic [31:0] RST_SYMBOL      = 32'd200000;
  localparam logic [15:0] RST_MARK        = 16'd1200;
  localparam logic [15:0] RST_SPACE       = 16'd2200;
  localparam logic [13:0] RST_OFFSET_STEP = 14'd150;

  // Divider widths: the tick rate is the dividend, a tone frequency the divisor.
  localparam int DVD_W = 30;
  localparam int DVS_W = 17;
  localparam int CNT_W = 5;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } fsk_div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } fsk_div_rsp_t;

endpackage

// ----- hw/rtl/fsk_div.sv -----
module fsk_div
  import fsk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  fsk_div_req_t req,
  output fsk_div_rsp_t rsp
);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] divisor;
  logic [CNT_W-1:0] count;
  logic             done;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem, quo[DVD_W-1]} - {1'b0, divisor};
  assign fits  = !trial[DVS_W];

  // Quotient bits shift in as dividend bits shift out.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (req.start) begin
      count <= CNT_W'(DVD_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - CNT_W'(1);
      done  <= (count == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (count != '0) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? trial[DVS_W-1:0] : {rem[DVS_W-2:0], quo[DVD_W-1]};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- hw/rtl/fsk_square_tone_modulator.sv -----
// A request that starts no tone passes through the evaluate state to its result.
// A request that starts a tone with a nonzero frequency also runs the shared 30-step divider.
// Requests are handled one at a time: the next is taken the cycle after the result is taken.
// Reset (rst, synchronous): the transmitter goes idle, all counters clear and the
// configuration registers return to their defaults.
module fsk_square_tone_modulator
  import fsk_pkg::*;
#(
  parameter int BITS_PER_BYTE = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        carrier_on,
  output logic        busy_res,
  output logic        load_rejected,
  output logic [2:0]  bit_position,
  output logic [1:0]  subtone_number
);

  localparam logic [3:0] LAST_BIT = 4'(BITS_PER_BYTE);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_TONE = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Configuration registers.
  logic        mode;
  logic [29:0] tick_rate_hz;
  logic [31:0] symbol_ticks;
  logic [15:0] mark_hz;
  logic [15:0] space_hz;
  logic [13:0] offset_step_hz;

  // Transmitter state.
  logic [2:0]  state, state_next;
  logic        req_opcode;
  logic [7:0]  req_data;
  logic [7:0]  byte_shift, byte_shift_next;
  logic [2:0]  bit_counter, bit_counter_next;
  logic [1:0]  subtone_counter, subtone_counter_next;
  logic [31:0] tone_elapsed, tone_elapsed_next;
  logic [31:0] period_length, period_length_next;
  logic [31:0] period_elapsed, period_elapsed_next;
  logic        sending, sending_next;
  logic        carrier_next, rejected_next;
  logic [2:0]  pos_next;
  logic [1:0]  sub_next;

  logic [31:0] tone_length;
  logic [31:0] pe_inc;
  logic [31:0] te_inc;
  logic [DVS_W-1:0] freq;
  logic [DVS_W-1:0] offset;

  fsk_div_req_t div_req;
  fsk_div_rsp_t div_rsp;

  fsk_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= RST_MODE;
      tick_rate_hz   <= RST_TICK_RATE;
      symbol_ticks   <= RST_SYMBOL;
      mark_hz        <= RST_MARK;
      space_hz       <= RST_SPACE;
      offset_step_hz <= RST_OFFSET_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        mode           <= cfg_data[0];
        REG_TICK_RATE:   tick_rate_hz   <= cfg_data[29:0];
        REG_SYMBOL:      symbol_ticks   <= cfg_data;
        REG_MARK:        mark_hz        <= cfg_data[15:0];
        REG_SPACE:       space_hz       <= cfg_data[15:0];
        REG_OFFSET_STEP: offset_step_hz <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Tone frequency for the current bit and subtone.
  always_comb begin
    offset = '0;
    if (mode) begin
      if (subtone_counter == 2'd1) begin
        offset = {2'b0, offset_step_hz, 1'b0};
      end else if (subtone_counter >= 2'd2) begin
        offset = {3'b0, offset_step_hz} + {2'b0, offset_step_hz, 1'b0};
      end
    end
    freq = (byte_shift[0] ? {1'b0, mark_hz} : {1'b0, space_hz}) + offset;
  end

  assign div_req.start    = (state == ST_TONE) && (freq != '0);
  assign div_req.dividend = tick_rate_hz;
  assign div_req.divisor  = freq;

  assign tone_length = mode ? {1'b0, symbol_ticks[31:1]} : symbol_ticks;
  assign pe_inc      = period_elapsed + 32'd1;
  assign te_inc      = (tone_elapsed == '1) ? tone_elapsed : tone_elapsed + 32'd1;

  // Sequencer and per-request state update.
  always_comb begin
    state_next           = state;
    byte_shift_next      = byte_shift;
    bit_counter_next     = bit_counter;
    subtone_counter_next = subtone_counter;
    tone_elapsed_next    = tone_elapsed;
    period_length_next   = period_length;
    period_elapsed_next  = period_elapsed;
    sending_next         = sending;
    carrier_next         = carrier_on;
    rejected_next        = load_rejected;
    pos_next             = bit_position;
    sub_next             = subtone_number;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        carrier_next  = 1'b0;
        rejected_next = 1'b0;
        pos_next      = '0;
        sub_next      = '0;
        state_next    = ST_DONE;
        if (req_opcode) begin
          if (sending) begin
            rejected_next = 1'b1;
            pos_next      = bit_counter;
            sub_next      = mode ? subtone_counter : 2'd0;
          end else begin
            byte_shift_next      = req_data;
            bit_counter_next     = '0;
            subtone_counter_next = '0;
            sending_next         = 1'b1;
            state_next           = ST_TONE;
          end
        end else if (sending) begin
          pos_next            = bit_counter;
          sub_next            = mode ? subtone_counter : 2'd0;
          carrier_next        = (period_elapsed < {1'b0, period_length[31:1]});
          period_elapsed_next = pe_inc;
          tone_elapsed_next   = te_inc;
          if (pe_inc >= period_length) begin
            if (te_inc < tone_length) begin
              period_elapsed_next = '0;
            end else if (mode && (subtone_counter < 2'd2)) begin
              subtone_counter_next = subtone_counter + 2'd1;
              state_next           = ST_TONE;
            end else begin
              subtone_counter_next = '0;
              if ({1'b0, bit_counter} + 4'd1 >= LAST_BIT) begin
                sending_next        = 1'b0;
                bit_counter_next    = '0;
                period_length_next  = '0;
                period_elapsed_next = '0;
                tone_elapsed_next   = '0;
              end else begin
                bit_counter_next = bit_counter + 3'd1;
                byte_shift_next  = {1'b0, byte_shift[7:1]};
                state_next       = ST_TONE;
              end
            end
          end
        end
      end
      ST_TONE: begin
        period_elapsed_next = '0;
        tone_elapsed_next   = '0;
        if (freq == '0) begin
          period_length_next = '1;
          state_next         = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          period_length_next = {2'b0, div_rsp.quotient};
          state_next         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      byte_shift      <= '0;
      bit_counter     <= '0;
      subtone_counter <= '0;
      tone_elapsed    <= '0;
      period_length   <= '0;
      period_elapsed  <= '0;
      sending         <= 1'b0;
    end else begin
      state           <= state_next;
      byte_shift      <= byte_shift_next;
      bit_counter     <= bit_counter_next;
      subtone_counter <= subtone_counter_next;
      tone_elapsed    <= tone_elapsed_next;
      period_length   <= period_length_next;
      period_elapsed  <= period_elapsed_next;
      sending         <= sending_next;
    end
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_opcode <= opcode;
      req_data   <= data_byte;
    end
    carrier_on     <= carrier_next;
    load_rejected  <= rejected_next;
    bit_position   <= pos_next;
    subtone_number <= sub_next;
  end

  assign busy_res = sending;

  // The input side is closed while a result waits.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  // An idle transmitter keeps no period and sits on bit zero.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (period_length == '0) && (bit_counter == '0))
    else $error("idle transmitter holds stale tone state");

  // The divider answers only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  // The bit index never passes the byte length.
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    sending |-> ({1'b0, bit_counter} < LAST_BIT))
    else $error("bit counter out of range");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import fsk_pkg::*;

  localparam int BITS_PER_BYTE = 7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;

  // Request opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic       carrier_on;
    logic       busy_res;
    logic       load_rejected;
    logic [2:0] bit_position;
    logic [1:0] subtone_number;
  } tone_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_MODE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OP_TICK;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        carrier_on;
  logic        busy_res;
  logic        load_rejected;
  logic [2:0]  bit_position;
  logic [1:0]  subtone_number;

  fsk_square_tone_modulator #(
    .BITS_PER_BYTE(BITS_PER_BYTE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .carrier_on(carrier_on),
    .busy_res(busy_res),
    .load_rejected(load_rejected),
    .bit_position(bit_position),
    .subtone_number(subtone_number)
  );

  // Free-running clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic        cfg_mode;
  logic [29:0] cfg_tick_rate;
  logic [31:0] cfg_symbol;
  logic [15:0] cfg_mark;
  logic [15:0] cfg_space;
  logic [13:0] cfg_step;

  // Shadow copy of the transmitter state.
  logic [7:0]  tx_shift;
  logic [2:0]  tx_bit;
  logic [1:0]  tx_sub;
  logic [31:0] tone_ticks;
  logic [31:0] period_ticks;
  logic [31:0] period_pos;
  logic        tx_active;

  tone_result_t expected_results[$];
  tone_result_t want;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  function automatic void reset_model();
    cfg_mode = RST_MODE;
    cfg_tick_rate = RST_TICK_RATE;
    cfg_symbol = RST_SYMBOL;
    cfg_mark = RST_MARK;
    cfg_space = RST_SPACE;
    cfg_step = RST_OFFSET_STEP;
    tx_shift = '0;
    tx_bit = '0;
    tx_sub = '0;
    tone_ticks = '0;
    period_ticks = '0;
    period_pos = '0;
    tx_active = 1'b0;
  endfunction

  // Pick the tone frequency of the current bit and subtone and divide it into the tick rate.
  function automatic void begin_tone();
    logic [31:0] freq;
    freq = tx_shift[0] ? {16'd0, cfg_mark} : {16'd0, cfg_space};
    if (cfg_mode) begin
      if (tx_sub == 2'd1) freq = freq + {17'd0, cfg_step, 1'b0};
      else if (tx_sub >= 2'd2) freq = freq + 3 * {18'd0, cfg_step};
    end
    period_ticks = (freq == 0) ? '1 : {2'b00, cfg_tick_rate} / freq;
    period_pos = '0;
    tone_ticks = '0;
  endfunction

  // Advance the shadow transmitter by one request and return the result it gives.
  function automatic tone_result_t predict_step(input logic op, input logic [7:0] dat);
    tone_result_t r;
    logic [31:0] limit;
    r = '0;
    if (op == OP_LOAD) begin
      if (tx_active) begin
        r.load_rejected = 1'b1;
      end else begin
        tx_shift = dat;
        tx_bit = '0;
        tx_sub = '0;
        tx_active = 1'b1;
        begin_tone();
      end
      r.bit_position = tx_bit;
      r.subtone_number = cfg_mode ? tx_sub : 2'd0;
    end else if (tx_active) begin
      r.bit_position = tx_bit;
      r.subtone_number = cfg_mode ? tx_sub : 2'd0;
      r.carrier_on = (period_pos < (period_ticks >> 1));
      period_pos = period_pos + 1;
      if (tone_ticks != '1) tone_ticks = tone_ticks + 1;
      limit = cfg_mode ? (cfg_symbol >> 1) : cfg_symbol;
      if (period_pos >= period_ticks) begin
        if (tone_ticks < limit) begin
          period_pos = '0;
        end else if (cfg_mode && tx_sub < 2'd2) begin
          tx_sub = tx_sub + 2'd1;
          begin_tone();
        end else begin
          tx_sub = '0;
          if (tx_bit + 1 >= BITS_PER_BYTE) begin
            tx_active = 1'b0;
            tx_bit = '0;
            period_ticks = '0;
            period_pos = '0;
            tone_ticks = '0;
          end else begin
            tx_bit = tx_bit + 3'd1;
            tx_shift = tx_shift >> 1;
            begin_tone();
          end
        end
      end
    end
    r.busy_res = tx_active;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with nothing expected");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("carrier_on", 32'(want.carrier_on), 32'(carrier_on));
        check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
        check_field("load_rejected", 32'(want.load_rejected), 32'(load_rejected));
        check_field("bit_position", 32'(want.bit_position), 32'(bit_position));
        check_field("subtone_number", 32'(want.subtone_number), 32'(subtone_number));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one request and wait until it is accepted. Returns at a falling edge with
  // valid still high, so that the next request can follow without a gap.
  task automatic send_item(input logic op, input logic [7:0] dat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_byte <= dat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_step(op, dat));
    @(negedge clk);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  // Tick until the shadow transmitter has sent the whole byte.
  task automatic finish_byte();
    while (tx_active) send_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Rewrite all registers once the block has nothing in flight.
  task automatic program_config(input logic m, input logic [29:0] rate, input logic [31:0] sym,
                                input logic [15:0] mk, input logic [15:0] sp,
                                input logic [13:0] st);
    wait_results_done();
    put_reg(REG_MODE, {31'd0, m});
    put_reg(REG_TICK_RATE, {2'd0, rate});
    put_reg(REG_SYMBOL, sym);
    put_reg(REG_MARK, {16'd0, mk});
    put_reg(REG_SPACE, {16'd0, sp});
    put_reg(REG_OFFSET_STEP, {18'd0, st});
    cfg_we <= 1'b0;
    cfg_mode = m;
    cfg_tick_rate = rate;
    cfg_symbol = sym;
    cfg_mark = mk;
    cfg_space = sp;
    cfg_step = st;
  endtask

  // Defaults after reset: an idle tick, then a byte on the default mode and frequencies over a
  // smaller tick rate, with a rejected load on the way and a shorter symbol length to finish it.
  task automatic test_reset_values();
    send_item(OP_TICK, 8'hFF);
    wait_results_done();
    put_reg(REG_TICK_RATE, 32'd4400);
    cfg_we <= 1'b0;
    cfg_tick_rate = 30'd4400;
    send_item(OP_LOAD, 8'hFE);
    send_ticks(3);
    send_item(OP_LOAD, 8'h01);
    wait_results_done();
    put_reg(REG_SYMBOL, 32'd2);
    cfg_we <= 1'b0;
    cfg_symbol = 32'd2;
    finish_byte();
  endtask

  // Single tone per bit with all-zero and all-one bytes and a rejected load.
  task automatic test_full_bytes_mode0();
    program_config(1'b0, 30'd12, 32'd3, 16'd6, 16'd4, 14'd0);
    send_item(OP_LOAD, 8'h00);
    finish_byte();
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_LOAD, 8'h5A);
    finish_byte();
  endtask

  // Three subtones per bit with distinct frequencies.
  task automatic test_subtones_mode1();
    program_config(1'b1, 30'd6, 32'd4, 16'd2, 16'd1, 14'd1);
    send_item(OP_LOAD, 8'h5A);
    finish_byte();
  endtask

  // Periods of zero and one tick, and the shortest tone lengths.
  task automatic test_short_periods();
    program_config(1'b0, 30'd1, 32'd2, 16'd1200, 16'd1200, 14'd0);
    send_item(OP_LOAD, 8'h3C);
    finish_byte();
    program_config(1'b0, 30'd5, 32'd2, 16'd5, 16'd5, 14'd0);
    send_item(OP_LOAD, 8'hC3);
    finish_byte();
    program_config(1'b1, 30'd2, 32'd2, 16'd1, 16'd2, 14'd0);
    send_item(OP_LOAD, 8'h96);
    finish_byte();
  endtask

  // Mode changes while a byte is on its way.
  task automatic test_mode_switch_mid_byte();
    program_config(1'b1, 30'd6, 32'd4, 16'd2, 16'd1, 14'd1);
    send_item(OP_LOAD, 8'hC3);
    send_ticks(5);
    program_config(1'b0, 30'd6, 32'd4, 16'd2, 16'd1, 14'd1);
    send_ticks(10);
    program_config(1'b1, 30'd6, 32'd4, 16'd2, 16'd1, 14'd1);
    finish_byte();
  endtask

  // Largest frequencies, step and symbol length over a wide tick rate. The first tone
  // runs without idling; the rest of the byte uses a smaller tick rate.
  task automatic test_extreme_settings();
    int saved_send;
    int saved_recv;
    saved_send = send_idle_pct;
    saved_recv = recv_idle_pct;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_config(1'b1, 30'd1966050, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
    send_item(OP_LOAD, 8'hB7);
    send_ticks(20);
    program_config(1'b1, 30'd229368, 32'd2, 16'hFFFF, 16'hFFFF, 14'h3FFF);
    finish_byte();
    send_idle_pct = saved_send;
    recv_idle_pct = saved_recv;
  endtask

  // A long receiver hold-off fills the block, then the sender waits for a full drain.
  task automatic test_backpressure();
    program_config(1'b0, 30'd30, 32'd4, 16'd10, 16'd6, 14'd0);
    send_item(OP_LOAD, 8'h2D);
    hold_cycles = 300;
    send_ticks(12);
    wait_results_done();
    send_ticks(5);
    finish_byte();
  endtask

  task automatic random_config();
    logic [15:0] mk;
    logic [15:0] sp;
    logic [15:0] lo;
    mk = 16'(($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 65535));
    sp = 16'(($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 65535));
    lo = (mk < sp) ? mk : sp;
    program_config(1'($urandom_range(1)), 30'($urandom_range(1, 4 * lo)),
                   $urandom_range(2, 6), mk, sp,
                   14'(($urandom_range(3) == 0) ? 0 : $urandom_range(16383)));
  endtask

  // Mostly complete bytes with random content; some loads land while busy.
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      random_config();
      repeat (count / 3) begin
        if (!tx_active) begin
          send_item(($urandom_range(99) < 70) ? OP_LOAD : OP_TICK, 8'($urandom_range(255)));
        end else if ($urandom_range(99) < 4) begin
          send_item(OP_LOAD, 8'($urandom_range(255)));
        end else begin
          send_item(OP_TICK, 8'($urandom_range(255)));
        end
      end
      finish_byte();
    end
  endtask

  initial begin
    reset_model();
    send_idle_pct = 32;
    recv_idle_pct = 69;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_full_bytes_mode0();
    test_subtones_mode1();
    test_short_periods();
    test_mode_switch_mid_byte();
    test_extreme_settings();
    test_backpressure();
    test_random_traffic(32, 69, 45);
    test_random_traffic(69, 32, 45);
    test_random_traffic(0, 0, 45);

    // Let the last results come out, then watch for stray ones.
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
